@@ rtl/core/abgt_pkg.sv @@
// shared types, codes and saturation helpers of the box tracker
package abgt_pkg;

  localparam int unsigned AXES = 6;

  localparam logic [2:0] AXIS_MIN_Z = 3'd2;
  localparam logic [2:0] AXIS_MAX_Z = 3'd5;
  localparam logic [2:0] AXIS_END   = 3'd6;

  localparam logic [1:0] DIM_FLAT = 2'd2;

  typedef enum logic [2:0] {
    CFG_DIMENSIONS    = 3'd0,
    CFG_GAIN_POSITION = 3'd1,
    CFG_GAIN_VELOCITY = 3'd2,
    CFG_GAIN_ACCEL    = 3'd3,
    CFG_STEP_TIME     = 3'd4,
    CFG_HALF_STEP_SQ  = 3'd5
  } abgt_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEL,
    ST_LOAD,
    ST_MUL,
    ST_DRAIN,
    ST_WRITE,
    ST_OUT
  } abgt_state_e;

  typedef enum logic [2:0] {
    OP_GAIN_P  = 3'd0,
    OP_GAIN_V  = 3'd1,
    OP_GAIN_A  = 3'd2,
    OP_VEL_DT  = 3'd3,
    OP_ACC_HSQ = 3'd4,
    OP_ACC_DT  = 3'd5
  } abgt_op_e;

  typedef struct packed {
    logic [1:0]  dimensions;
    logic [15:0] gain_position;
    logic [23:0] gain_velocity;
    logic [23:0] gain_accel;
    logic [23:0] step_time;
    logic [23:0] half_step_sq;
  } abgt_cfg_t;

  typedef struct packed {
    logic       capture;
    logic       clear;
    logic       rd;
    logic       load;
    logic       mul;
    abgt_op_e   op;
    logic [2:0] axis;
    logic       wr;
    logic       out_load;
  } abgt_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic found;
    logic first;
    logic flat;
    logic in_range;
    logic out_free;
  } abgt_sts_t;

  // product scaled by 2^-16, rounding half up (arithmetic shift floors)
  function automatic logic signed [43:0] scale_rnd(input logic signed [58:0] p);
    logic signed [59:0] t;
    t = 60'(p) + 60'sd32768;
    return t[59:16];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [45:0] x);
    logic signed [31:0] r;
    if (x > 46'sd2147483647) r = 32'sh7fffffff;
    else if (x < -46'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
    logic signed [23:0] r;
    if (x > 32'sd8388607) r = 24'sh7fffff;
    else if (x < -32'sd8388608) r = 24'sh800000;
    else r = x[23:0];
    return r;
  endfunction

endpackage

@@ rtl/core/abgt_ram.sv @@
// generic single write, single registered read memory
module abgt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 384,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/abgt_ctrl.sv @@
// sequencer of the box tracker: axis walk, multiply schedule, result hand-off
module abgt_ctrl import abgt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  abgt_sts_t sts_i,
  output abgt_cmd_t cmd_o
);

  abgt_state_e state_q, state_d;
  logic [2:0]  axis_q, axis_d;
  abgt_op_e    op_q, op_d;
  logic        skip;

  assign skip = sts_i.flat && (axis_q == AXIS_MIN_Z || axis_q == AXIS_MAX_Z);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      axis_q  <= '0;
      op_q    <= OP_GAIN_P;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      op_q    <= op_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    op_d    = op_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SEL;
          axis_d  = '0;
        end
      end
      ST_SEL: begin
        if (!sts_i.in_range || axis_q == AXIS_END) state_d = ST_OUT;
        else if (skip) axis_d = axis_q + 3'd1;
        else state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts_i.found && sts_i.first) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_MUL;
          op_d    = sts_i.found ? OP_GAIN_P : OP_VEL_DT;
        end
      end
      ST_MUL: begin
        case (op_q)
          OP_GAIN_P:  op_d = OP_GAIN_V;
          OP_GAIN_V:  op_d = OP_GAIN_A;
          OP_GAIN_A:  op_d = OP_VEL_DT;
          OP_VEL_DT:  op_d = OP_ACC_HSQ;
          OP_ACC_HSQ: op_d = OP_ACC_DT;
          default:    state_d = ST_DRAIN;
        endcase
      end
      ST_DRAIN: state_d = ST_WRITE;
      ST_WRITE: begin
        state_d = ST_SEL;
        axis_d  = axis_q + 3'd1;
      end
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = op_q;
    cmd_o.axis = axis_q;
    in_stall_o = 1'b1;
    case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_SEL:   cmd_o.rd = sts_i.in_range && axis_q != AXIS_END && !skip;
      ST_LOAD:  cmd_o.load = 1'b1;
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_DRAIN: cmd_o.mul = 1'b0;
      ST_WRITE: cmd_o.wr = 1'b1;
      ST_OUT:   cmd_o.out_load = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && op_q == OP_ACC_DT) |=> state_q == ST_DRAIN)
    else $error("multiply schedule did not end in drain");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WRITE |-> ($past(state_q) == ST_DRAIN || $past(state_q) == ST_LOAD))
    else $error("table write without a finished update");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> in_stall_o)
    else $error("second transaction taken while one is in work");

endmodule

@@ rtl/core/abgt_dp.sv @@
// datapath: track table, shared multiplier, accumulators and result registers
module abgt_dp import abgt_pkg::*; #(
  parameter int MAX_TRACKS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  abgt_cfg_t          cfg_i,
  input  abgt_cmd_t          cmd_i,
  output abgt_sts_t          sts_o,
  input  logic [5:0]         track_i,
  input  logic               found_i,
  input  logic               first_observation_i,
  input  logic signed [23:0] min_x_i,
  input  logic signed [23:0] min_y_i,
  input  logic signed [23:0] min_z_i,
  input  logic signed [23:0] far_x_i,
  input  logic signed [23:0] far_y_i,
  input  logic signed [23:0] far_z_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [5:0]         track_out_o,
  output logic signed [23:0] pred_min_x_o,
  output logic signed [23:0] pred_min_y_o,
  output logic signed [23:0] pred_min_z_o,
  output logic signed [23:0] pred_max_x_o,
  output logic signed [23:0] pred_max_y_o,
  output logic signed [23:0] pred_max_z_o
);

  localparam int Depth = MAX_TRACKS * AXES;
  localparam int AddrW = $clog2(Depth);

  logic              flat;
  logic [5:0]        track_q;
  logic              found_q, first_q, in_range_q;
  logic signed [24:0] meas_q [AXES];
  logic [AddrW-1:0]  base_q, addr, clr_q, waddr;
  logic [12:0]       base_full;
  logic              clear_done;

  logic signed [31:0] p_q, v_q, a_q, p_rd, v_rd, a_rd;
  logic signed [33:0] r_q;
  logic signed [45:0] np_q, nv_q;
  logic signed [58:0] prod_q, prod_d;
  logic signed [33:0] mul_a;
  logic        [23:0] mul_b;
  logic               ret_valid_q;
  abgt_op_e           ret_op_q;
  logic signed [43:0] sr;
  logic signed [24:0] meas_sel;
  logic signed [31:0] p_new, v_new;

  logic signed [23:0] res_q [AXES];
  logic               out_valid_q;
  logic               we;

  assign flat      = cfg_i.dimensions == DIM_FLAT;
  assign base_full = 13'(track_i) * 13'd6;
  assign addr      = base_q + AddrW'(cmd_i.axis);
  assign clear_done = clr_q == AddrW'(Depth - 1);
  assign meas_sel  = meas_q[cmd_i.axis];

  // item capture, far corner from width and height in image mode
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      track_q    <= track_i;
      found_q    <= found_i;
      first_q    <= first_observation_i;
      in_range_q <= 32'(track_i) < 32'(MAX_TRACKS);
      base_q     <= base_full[AddrW-1:0];
      meas_q[0]  <= 25'(min_x_i);
      meas_q[1]  <= 25'(min_y_i);
      meas_q[2]  <= 25'(min_z_i);
      meas_q[3]  <= flat ? 25'(far_x_i) + 25'(min_x_i) : 25'(far_x_i);
      meas_q[4]  <= flat ? 25'(far_y_i) + 25'(min_y_i) : 25'(far_y_i);
      meas_q[5]  <= 25'(far_z_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear && !clear_done) begin
      clr_q <= clr_q + AddrW'(1);
    end
  end

  // shared multiplier
  always_comb begin
    case (cmd_i.op)
      OP_GAIN_P:  begin mul_a = r_q;        mul_b = 24'(cfg_i.gain_position); end
      OP_GAIN_V:  begin mul_a = r_q;        mul_b = cfg_i.gain_velocity;      end
      OP_GAIN_A:  begin mul_a = r_q;        mul_b = cfg_i.gain_accel;         end
      OP_VEL_DT:  begin mul_a = 34'(v_q);   mul_b = cfg_i.step_time;          end
      OP_ACC_HSQ: begin mul_a = 34'(a_q);   mul_b = cfg_i.half_step_sq;       end
      OP_ACC_DT:  begin mul_a = 34'(a_q);   mul_b = cfg_i.step_time;          end
      default:    begin mul_a = '0;         mul_b = '0;                       end
    endcase
  end

  assign prod_d = 59'(mul_a) * 59'($signed({1'b0, mul_b}));
  assign sr     = scale_rnd(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ret_valid_q <= 1'b0;
      ret_op_q    <= OP_GAIN_P;
    end else begin
      ret_valid_q <= cmd_i.mul;
      ret_op_q    <= cmd_i.op;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= prod_d;
    if (cmd_i.load) begin
      p_q  <= p_rd;
      v_q  <= v_rd;
      a_q  <= (found_q && first_q) ? 32'sd0 : a_rd;
      r_q  <= 34'(meas_sel) - 34'(p_rd);
      np_q <= 46'(meas_sel);
      nv_q <= '0;
    end else if (ret_valid_q) begin
      case (ret_op_q)
        OP_GAIN_P:  p_q  <= sat32(46'(p_q) + 46'(sr));
        OP_GAIN_V:  v_q  <= sat32(46'(v_q) + 46'(sr));
        OP_GAIN_A:  a_q  <= sat32(46'(a_q) + 46'(sr));
        OP_VEL_DT:  np_q <= 46'(p_q) + 46'(sr);
        OP_ACC_HSQ: np_q <= np_q + 46'(sr);
        OP_ACC_DT:  nv_q <= 46'(v_q) + 46'(sr);
        default:    np_q <= np_q;
      endcase
    end
  end

  assign p_new = sat32(np_q);
  assign v_new = sat32(nv_q);

  // track table, zeroed by a sweep after reset
  assign we    = cmd_i.wr || cmd_i.clear;
  assign waddr = cmd_i.clear ? clr_q : addr;

  abgt_ram #(.WIDTH(32), .DEPTH(Depth)) u_pos (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(cmd_i.clear ? '0 : p_new),
    .re_i(cmd_i.rd), .raddr_i(addr), .rdata_o(p_rd)
  );

  abgt_ram #(.WIDTH(32), .DEPTH(Depth)) u_vel (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(cmd_i.clear ? '0 : v_new),
    .re_i(cmd_i.rd), .raddr_i(addr), .rdata_o(v_rd)
  );

  abgt_ram #(.WIDTH(32), .DEPTH(Depth)) u_acc (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(cmd_i.clear ? '0 : a_q),
    .re_i(cmd_i.rd), .raddr_i(addr), .rdata_o(a_rd)
  );

  // per-axis results
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < AXES; i++) res_q[i] <= '0;
    end else if (cmd_i.wr) begin
      res_q[cmd_i.axis] <= sat24(p_new);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      track_out_o  <= track_q;
      pred_min_x_o <= res_q[0];
      pred_min_y_o <= res_q[1];
      pred_min_z_o <= res_q[2];
      pred_max_x_o <= res_q[3];
      pred_max_y_o <= res_q[4];
      pred_max_z_o <= res_q[5];
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.clear_done = clear_done;
  assign sts_o.found      = found_q;
  assign sts_o.first      = first_q;
  assign sts_o.flat       = flat;
  assign sts_o.in_range   = in_range_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

endmodule

@@ rtl/core/alpha_beta_gamma_box_tracker.sv @@
// top level of the alpha-beta-gamma box corner tracker
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------------
//   in      | in        | in_valid_i / in_stall_o | track, found, first, min/far xyz
//   out     | out       | out_valid_o/ out_stall_i| track_out, pred_min/max xyz
//   cfg     | in        | cfg_we_i                | cfg_addr_i, cfg_data_i
//
// per transaction, each active axis is read from the table and written back; with a
// measurement the gain updates and the predict products run, predict only runs the
// predict products, and a first observation writes the measurement directly (six axes,
// four in image mode, where the z axes are skipped); all products use the single shared multiplier
// after reset a sweep over all 6*MAX_TRACKS entries zeroes the track table; no input is taken
// then, and the next transaction is taken while a result still waits in the output register
module alpha_beta_gamma_box_tracker import abgt_pkg::*; #(
  parameter int MAX_TRACKS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [23:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [5:0]         track_i,
  input  logic               found_i,
  input  logic               first_observation_i,
  input  logic signed [23:0] min_x_i,
  input  logic signed [23:0] min_y_i,
  input  logic signed [23:0] min_z_i,
  input  logic signed [23:0] far_x_i,
  input  logic signed [23:0] far_y_i,
  input  logic signed [23:0] far_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [5:0]         track_out_o,
  output logic signed [23:0] pred_min_x_o,
  output logic signed [23:0] pred_min_y_o,
  output logic signed [23:0] pred_min_z_o,
  output logic signed [23:0] pred_max_x_o,
  output logic signed [23:0] pred_max_y_o,
  output logic signed [23:0] pred_max_z_o
);

  abgt_cfg_t cfg_q;
  abgt_cmd_t cmd;
  abgt_sts_t sts;

  // configuration registers, indexes past the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dimensions    <= 2'd3;
      cfg_q.gain_position <= 16'd32768;
      cfg_q.gain_velocity <= '0;
      cfg_q.gain_accel    <= '0;
      cfg_q.step_time     <= 24'd2185;
      cfg_q.half_step_sq  <= 24'd36;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_DIMENSIONS:    cfg_q.dimensions    <= cfg_data_i[1:0];
        CFG_GAIN_POSITION: cfg_q.gain_position <= cfg_data_i[15:0];
        CFG_GAIN_VELOCITY: cfg_q.gain_velocity <= cfg_data_i;
        CFG_GAIN_ACCEL:    cfg_q.gain_accel    <= cfg_data_i;
        CFG_STEP_TIME:     cfg_q.step_time     <= cfg_data_i;
        CFG_HALF_STEP_SQ:  cfg_q.half_step_sq  <= cfg_data_i;
        default:           cfg_q <= cfg_q;
      endcase
    end
  end

  // sequencer
  abgt_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  // table, arithmetic and output register
  abgt_dp #(.MAX_TRACKS(MAX_TRACKS)) u_dp (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg_q),
    .cmd_i (cmd),
    .sts_o (sts),
    .track_i,
    .found_i,
    .first_observation_i,
    .min_x_i,
    .min_y_i,
    .min_z_i,
    .far_x_i,
    .far_y_i,
    .far_z_i,
    .out_stall_i,
    .out_valid_o,
    .track_out_o,
    .pred_min_x_o,
    .pred_min_y_o,
    .pred_min_z_o,
    .pred_max_x_o,
    .pred_max_y_o,
    .pred_max_z_o
  );

endmodule
